// ----- rtl/per_class_box_suppression_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the per-class box suppression core
// Shared shorthand for the concurrent checks in the port checker.
// ----------------------------------------------------------------------------
`ifndef PER_CLASS_BOX_SUPPRESSION_CORE_DEFINES_SVH
`define PER_CLASS_BOX_SUPPRESSION_CORE_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define PBS_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("port check failed");

// Clocked check that holds in reset as well.
`define PBS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("port check failed");

`endif

// ----- rtl/pbs_pkg.sv -----
// ----------------------------------------------------------------------------
// pbs_pkg
// Types and constants shared by the box suppression core modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbs_pkg;

  // Store capacity and derived widths.
  localparam int MAX_DET = 64;
  localparam int IDX_W   = $clog2(MAX_DET);
  localparam int CNT_W   = IDX_W + 1;

  // Register map.
  localparam int          ADDR_W        = 3;
  localparam logic [2:0]  ADDR_SCORE_THR = 3'd0;
  localparam logic [2:0]  ADDR_OVL_THR   = 3'd4;
  localparam logic [15:0] SCORE_THR_RST  = 16'd16384;
  localparam logic [15:0] OVL_THR_RST    = 16'd29491;

  // One detection word on the input channel.
  typedef struct packed {
    logic [15:0] ctr_x;
    logic [15:0] ctr_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] score;
    logic [7:0]  class_label;
    logic        final_item;
  } pbs_det_t;

  // One result word on the output channel.
  typedef struct packed {
    logic [15:0] kept_x;
    logic [15:0] kept_y;
    logic [15:0] kept_width;
    logic [15:0] kept_height;
    logic [15:0] kept_score;
    logic [7:0]  kept_class;
    logic        run_end;
    logic        none_kept;
  } pbs_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic scan_start;
    logic scan_supp;
    logic take_best;
    logic emit_pend;
    logic emit_last;
    logic frame_clr;
  } pbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_acc;
    logic scan_done;
    logic best_vld;
    logic pend_vld;
    logic out_free;
  } pbs_stat_t;

endpackage

// ----- rtl/pbs_if.sv -----
// ----------------------------------------------------------------------------
// pbs_in_if / pbs_out_if
// Valid/ready channels for detection words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pbs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ctr_x;
  logic [15:0] ctr_y;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic [15:0] score;
  logic [7:0]  class_label;
  logic        final_item;

  modport source (output valid, ctr_x, ctr_y, box_width, box_height, score,
                  class_label, final_item, input ready);
  modport sink (input valid, ctr_x, ctr_y, box_width, box_height, score,
                class_label, final_item, output ready);
endinterface

interface pbs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] kept_x;
  logic [15:0] kept_y;
  logic [15:0] kept_width;
  logic [15:0] kept_height;
  logic [15:0] kept_score;
  logic [7:0]  kept_class;
  logic        run_end;
  logic        none_kept;

  modport source (output valid, kept_x, kept_y, kept_width, kept_height, kept_score,
                  kept_class, run_end, none_kept, input ready);
  modport sink (input valid, kept_x, kept_y, kept_width, kept_height, kept_score,
                kept_class, run_end, none_kept, output ready);
endinterface

// ----- rtl/per_class_box_suppression_core.sv -----
// ----------------------------------------------------------------------------
// per_class_box_suppression_core
// Per-class greedy non-maximum suppression over a frame of detections.
// ----------------------------------------------------------------------------
// Detections are taken one per cycle while the core is loading; those above
// the score threshold are stored, up to 64 per frame. The word flagged
// final_item starts suppression: each round sweeps the n stored entries to
// find the next survivor (lowest class, highest score, earliest load), then
// sweeps them again through the overlap pipeline to drop same-class boxes.
// Each round is bounded by these two sweeps over the single-ported store.
// Survivors leave in order, the last with run_end; a frame with none gives
// one word with none_kept. Input is held off until the frame's last word has
// been registered for output.
`timescale 1ns / 1ps

module per_class_box_suppression_core import pbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pbs_in_if.sink            in_ch,
  pbs_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] score_thr_r, overlap_thr_r;
  pbs_cmd_t    cmd;
  pbs_stat_t   stat;
  pbs_det_t    det;
  pbs_res_t    res;
  logic        load_en, out_valid;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_thr_r   <= SCORE_THR_RST;
      overlap_thr_r <= OVL_THR_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == ADDR_SCORE_THR) begin
        score_thr_r <= pwdata[15:0];
      end else if (paddr == ADDR_OVL_THR) begin
        overlap_thr_r <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_SCORE_THR) begin
      prdata = {16'b0, score_thr_r};
    end else if (paddr == ADDR_OVL_THR) begin
      prdata = {16'b0, overlap_thr_r};
    end
  end

  // Channel packing.
  assign det = '{ctr_x: in_ch.ctr_x, ctr_y: in_ch.ctr_y,
                 box_width: in_ch.box_width, box_height: in_ch.box_height,
                 score: in_ch.score, class_label: in_ch.class_label,
                 final_item: in_ch.final_item};
  assign in_ch.ready        = load_en;
  assign out_ch.valid       = out_valid;
  assign out_ch.kept_x      = res.kept_x;
  assign out_ch.kept_y      = res.kept_y;
  assign out_ch.kept_width  = res.kept_width;
  assign out_ch.kept_height = res.kept_height;
  assign out_ch.kept_score  = res.kept_score;
  assign out_ch.kept_class  = res.kept_class;
  assign out_ch.run_end     = res.run_end;
  assign out_ch.none_kept   = res.none_kept;

  pbs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .cmd     (cmd),
    .load_en (load_en)
  );

  pbs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .load_en     (load_en),
    .in_valid    (in_ch.valid),
    .in_det      (det),
    .out_ready   (out_ch.ready),
    .score_thr   (score_thr_r),
    .overlap_thr (overlap_thr_r),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_res     (res)
  );

endmodule

// ----- rtl/pbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbs_ctrl
// Frame sequencer: load, then alternate best-search and suppression scans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbs_ctrl import pbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  pbs_stat_t stat,
  output pbs_cmd_t  cmd,
  output logic      load_en
);

  typedef enum logic [2:0] {
    S_LOAD, S_FIND_ARM, S_FIND_WAIT, S_EMIT, S_TAKE, S_SUPP_ARM, S_SUPP_WAIT, S_FINISH
  } state_t;

  state_t   state_r, state_nxt;
  pbs_cmd_t cmd_r, cmd_nxt;
  logic     load_en_r, load_en_nxt;
  logic     clear_r, clear_nxt;

  assign cmd     = cmd_r;
  assign load_en = load_en_r;

  // Next state and command pulses.
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = '0;
    load_en_nxt = load_en_r;
    clear_nxt   = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (clear_r) begin
          load_en_nxt = 1'b1;
        end else if (stat.final_acc) begin
          load_en_nxt        = 1'b0;
          cmd_nxt.scan_start = 1'b1;
          state_nxt          = S_FIND_ARM;
        end
      end
      S_FIND_ARM: begin
        state_nxt = S_FIND_WAIT;
      end
      S_FIND_WAIT: begin
        if (stat.scan_done) begin
          if (!stat.best_vld) begin
            state_nxt = S_FINISH;
          end else if (!stat.pend_vld || stat.out_free) begin
            cmd_nxt.emit_pend = stat.pend_vld;
            cmd_nxt.take_best = 1'b1;
            state_nxt         = S_TAKE;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd_nxt.emit_pend = 1'b1;
          cmd_nxt.take_best = 1'b1;
          state_nxt         = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd_nxt.scan_start = 1'b1;
        cmd_nxt.scan_supp  = 1'b1;
        state_nxt          = S_SUPP_ARM;
      end
      S_SUPP_ARM: begin
        state_nxt = S_SUPP_WAIT;
      end
      S_SUPP_WAIT: begin
        if (stat.scan_done) begin
          cmd_nxt.scan_start = 1'b1;
          state_nxt          = S_FIND_ARM;
        end
      end
      S_FINISH: begin
        // The frame clear lands while loading is still held off.
        if (stat.out_free) begin
          cmd_nxt.emit_last = 1'b1;
          cmd_nxt.frame_clr = 1'b1;
          clear_nxt         = 1'b1;
          state_nxt         = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // State register with registered command pulses.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cmd_r     <= '0;
      load_en_r <= 1'b1;
      clear_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmd_r     <= cmd_nxt;
      load_en_r <= load_en_nxt;
      clear_r   <= clear_nxt;
    end
  end

endmodule

// ----- rtl/pbs_datapath.sv -----
// ----------------------------------------------------------------------------
// pbs_datapath
// Detection stores, scan engine, overlap pipeline and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbs_datapath import pbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pbs_cmd_t    cmd,
  input  logic        load_en,
  input  logic        in_valid,
  input  pbs_det_t    in_det,
  input  logic        out_ready,
  input  logic [15:0] score_thr,
  input  logic [15:0] overlap_thr,
  output pbs_stat_t   stat,
  output logic        out_valid,
  output pbs_res_t    out_res
);

  // Stores.
  logic [63:0] box_mem [MAX_DET];
  logic [23:0] sc_mem  [MAX_DET];

  logic [CNT_W-1:0]   count_r;
  logic [MAX_DET-1:0] removed_r;
  logic [IDX_W-1:0]   addr_r, rd_idx_r;
  logic               scanning_r, rd_vld_r, supp_mode_r;
  logic [63:0]        box_q;
  logic [23:0]        sc_q;

  logic [63:0]      best_box_r, pend_box_r;
  logic [23:0]      best_sc_r, pend_sc_r;
  logic [IDX_W-1:0] best_idx_r;
  logic             best_vld_r, pend_vld_r, out_vld_r;
  pbs_res_t         out_r;

  logic load_acc, store;
  assign load_acc = load_en & in_valid;
  assign store    = load_acc && (in_det.score > score_thr) &&
                    (count_r < CNT_W'(MAX_DET));

  // Store write on load, registered read for the scans.
  always_ff @(posedge clk) begin
    if (store) begin
      box_mem[count_r[IDX_W-1:0]] <= {in_det.box_height, in_det.box_width,
                                      in_det.ctr_y, in_det.ctr_x};
      sc_mem[count_r[IDX_W-1:0]]  <= {in_det.score, in_det.class_label};
    end
    box_q <= box_mem[addr_r];
    sc_q  <= sc_mem[addr_r];
  end

  // Best-candidate compare: lower class, then higher score; ties keep scan order.
  logic cand_live, better;
  assign cand_live = rd_vld_r && !removed_r[rd_idx_r];
  assign better    = !best_vld_r || (sc_q[7:0] < best_sc_r[7:0]) ||
                     ((sc_q[7:0] == best_sc_r[7:0]) && (sc_q[23:8] > best_sc_r[23:8]));

  // Overlap pipeline, stage one: doubled edges and intersection extents.
  logic signed [18:0] l1, r1, t1, d1, l2, r2, t2, d2, lm, rm, tm, dm, dwx, dhx;
  logic               s0_vld, ok0;
  assign s0_vld = cand_live && supp_mode_r && (sc_q[7:0] == pend_sc_r[7:0]);
  assign l1 = $signed({2'b0, pend_box_r[15:0], 1'b0}) - $signed({3'b0, pend_box_r[47:32]});
  assign r1 = $signed({2'b0, pend_box_r[15:0], 1'b0}) + $signed({3'b0, pend_box_r[47:32]});
  assign t1 = $signed({2'b0, pend_box_r[31:16], 1'b0}) - $signed({3'b0, pend_box_r[63:48]});
  assign d1 = $signed({2'b0, pend_box_r[31:16], 1'b0}) + $signed({3'b0, pend_box_r[63:48]});
  assign l2 = $signed({2'b0, box_q[15:0], 1'b0}) - $signed({3'b0, box_q[47:32]});
  assign r2 = $signed({2'b0, box_q[15:0], 1'b0}) + $signed({3'b0, box_q[47:32]});
  assign t2 = $signed({2'b0, box_q[31:16], 1'b0}) - $signed({3'b0, box_q[63:48]});
  assign d2 = $signed({2'b0, box_q[31:16], 1'b0}) + $signed({3'b0, box_q[63:48]});
  assign lm  = (l1 > l2) ? l1 : l2;
  assign rm  = (r1 < r2) ? r1 : r2;
  assign tm  = (t1 > t2) ? t1 : t2;
  assign dm  = (d1 < d2) ? d1 : d2;
  assign dwx = rm - lm;
  assign dhx = dm - tm;
  assign ok0 = (lm <= rm) && (tm <= dm);

  logic [17:0]      dw1_r, dh1_r;
  logic [15:0]      aw1_r, ah1_r, bw1_r, bh1_r;
  logic [35:0]      inter2_r, inter3_r, uni3_r;
  logic [31:0]      area_a2_r, area_b2_r;
  logic [51:0]      prod4_r, lhs4_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r, idx4_r;
  logic             v1_r, v2_r, v3_r, v4_r, ok1_r, ok2_r, ok3_r, ok4_r;
  logic             hit;

  // Stages two to four: products, union, threshold product.
  always_ff @(posedge clk) begin
    dw1_r  <= dwx[17:0];
    dh1_r  <= dhx[17:0];
    aw1_r  <= pend_box_r[47:32];
    ah1_r  <= pend_box_r[63:48];
    bw1_r  <= box_q[47:32];
    bh1_r  <= box_q[63:48];
    ok1_r  <= ok0;
    idx1_r <= rd_idx_r;

    inter2_r  <= 36'(dw1_r) * 36'(dh1_r);
    area_a2_r <= 32'(aw1_r) * 32'(ah1_r);
    area_b2_r <= 32'(bw1_r) * 32'(bh1_r);
    ok2_r     <= ok1_r;
    idx2_r    <= idx1_r;

    uni3_r   <= {2'b0, area_a2_r, 2'b0} + {2'b0, area_b2_r, 2'b0} - inter2_r;
    inter3_r <= inter2_r;
    ok3_r    <= ok2_r;
    idx3_r   <= idx2_r;

    prod4_r <= 52'(overlap_thr) * 52'(uni3_r);
    lhs4_r  <= {inter3_r, 16'b0};
    ok4_r   <= ok3_r;
    idx4_r  <= idx3_r;
  end

  assign hit = v4_r && ok4_r && (lhs4_r > prod4_r);

  // Best and pending survivor payloads.
  always_ff @(posedge clk) begin
    if (cand_live && !supp_mode_r && better) begin
      best_box_r <= box_q;
      best_sc_r  <= sc_q;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.take_best) begin
      pend_box_r <= best_box_r;
      pend_sc_r  <= best_sc_r;
    end
    if (cmd.emit_pend) begin
      out_r <= {pend_box_r[15:0], pend_box_r[31:16], pend_box_r[47:32],
                pend_box_r[63:48], pend_sc_r[23:8], pend_sc_r[7:0], 1'b0, 1'b0};
    end else if (cmd.emit_last) begin
      if (pend_vld_r) begin
        out_r <= {pend_box_r[15:0], pend_box_r[31:16], pend_box_r[47:32],
                  pend_box_r[63:48], pend_sc_r[23:8], pend_sc_r[7:0], 1'b1, 1'b0};
      end else begin
        // Empty frame: zero fields with both markers set.
        out_r <= {88'b0, 1'b1, 1'b1};
      end
    end
  end

  // Control state: fill count, scan counter, flags and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      removed_r   <= '0;
      addr_r      <= '0;
      scanning_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_idx_r    <= '0;
      supp_mode_r <= 1'b0;
      best_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      if (store) begin
        count_r <= count_r + CNT_W'(1);
      end

      // Address sweep over the filled entries.
      rd_vld_r <= scanning_r;
      rd_idx_r <= addr_r;
      if (cmd.scan_start) begin
        addr_r      <= '0;
        scanning_r  <= (count_r != '0);
        supp_mode_r <= cmd.scan_supp;
        if (!cmd.scan_supp) begin
          best_vld_r <= 1'b0;
        end
      end else if (scanning_r) begin
        addr_r <= addr_r + IDX_W'(1);
        if ({1'b0, addr_r} == count_r - CNT_W'(1)) begin
          scanning_r <= 1'b0;
        end
      end

      if (cand_live && !supp_mode_r && better) begin
        best_vld_r <= 1'b1;
      end

      v1_r <= s0_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;

      if (hit) begin
        removed_r[idx4_r] <= 1'b1;
      end
      if (cmd.take_best) begin
        removed_r[best_idx_r] <= 1'b1;
        pend_vld_r            <= 1'b1;
      end

      if (cmd.emit_pend || cmd.emit_last) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_ready) begin
        out_vld_r <= 1'b0;
      end

      if (cmd.frame_clr) begin
        count_r    <= '0;
        removed_r  <= '0;
        pend_vld_r <= 1'b0;
      end
    end
  end

  assign stat.final_acc = load_acc & in_det.final_item;
  assign stat.scan_done = !scanning_r && !rd_vld_r && !v1_r && !v2_r && !v3_r && !v4_r;
  assign stat.best_vld  = best_vld_r;
  assign stat.pend_vld  = pend_vld_r;
  assign stat.out_free  = !out_vld_r;
  assign out_valid      = out_vld_r;
  assign out_res        = out_r;

endmodule

// ----- rtl/pbs_checker.sv -----
// ----------------------------------------------------------------------------
// pbs_checker
// Port-level checks on the result channel and configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_class_box_suppression_core_defines.svh"

module pbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] kept_score,
  input logic [7:0]  kept_class,
  input logic [15:0] kept_width,
  input logic        run_end,
  input logic        none_kept,
  input logic        pready
);

  // A stalled result word holds its marker bits.
  `PBS_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(run_end) && $stable(none_kept))

  // An empty frame result closes the frame and carries zero fields.
  `PBS_ASSERT_RST(a_none_form, clk, rst_n, out_valid && none_kept |-> run_end && kept_score == 16'd0 && kept_class == 8'd0 && kept_width == 16'd0)

  // A survivor always scored above zero, since it beat the threshold.
  `PBS_ASSERT_RST(a_kept_score, clk, rst_n, out_valid && !none_kept |-> kept_score != 16'd0)

  // The configuration port never stalls.
  `PBS_ASSERT_ALWAYS(a_pready, clk, pready)

endmodule

bind per_class_box_suppression_core pbs_checker u_pbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kept_score (out_ch.kept_score),
  .kept_class (out_ch.kept_class),
  .kept_width (out_ch.kept_width),
  .run_end    (out_ch.run_end),
  .none_kept  (out_ch.none_kept),
  .pready     (pready)
);

// ----- verif/per_class_box_suppression_core_tb.sv -----
// ----------------------------------------------------------------------------
// per_class_box_suppression_core_tb
// Loads frames of detections into the suppression core and checks every result
// word against a behavioral model of per-class greedy non-maximum suppression.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_class_box_suppression_core_tb;
  import pbs_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  pbs_in_if  det_ch ();
  pbs_out_if res_ch ();

  per_class_box_suppression_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (det_ch.sink),
    .out_ch  (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state: the current frame and the two thresholds.
  pbs_det_t    frame_dets[$];
  logic [15:0] score_thr;
  logic [15:0] ovl_thr;

  pbs_det_t pending_dets[$];
  pbs_res_t expected_results[$];
  int       mismatch_count;
  int       sent_count;
  int       frame_end_count;
  bit       hold_off_req;
  int       hold_off_left;

  // True when box b overlaps kept box a by more than the overlap threshold.
  function automatic bit overlap_exceeds(pbs_det_t a, pbs_det_t b);
    longint l1, r1, t1, d1, l2, r2, t2, d2, l, r, t, d;
    longint unsigned inter, uni;
    l1 = 2 * longint'(a.ctr_x) - a.box_width;
    r1 = 2 * longint'(a.ctr_x) + a.box_width;
    t1 = 2 * longint'(a.ctr_y) - a.box_height;
    d1 = 2 * longint'(a.ctr_y) + a.box_height;
    l2 = 2 * longint'(b.ctr_x) - b.box_width;
    r2 = 2 * longint'(b.ctr_x) + b.box_width;
    t2 = 2 * longint'(b.ctr_y) - b.box_height;
    d2 = 2 * longint'(b.ctr_y) + b.box_height;
    l = (l1 > l2) ? l1 : l2;
    r = (r1 < r2) ? r1 : r2;
    t = (t1 > t2) ? t1 : t2;
    d = (d1 < d2) ? d1 : d2;
    if (t > d || l > r) return 0;
    inter = longint'(r - l) * longint'(d - t);
    uni = 4 * longint'(a.box_width) * a.box_height
        + 4 * longint'(b.box_width) * b.box_height - inter;
    return (inter * 65536) > (longint'(ovl_thr) * uni);
  endfunction

  // Sort-before rule: ascending class, falling score, then load order.
  function automatic bit ranks_ahead(pbs_det_t a, int ia, pbs_det_t b, int ib);
    if (a.class_label != b.class_label) return a.class_label < b.class_label;
    if (a.score != b.score) return a.score > b.score;
    return ia < ib;
  endfunction

  // Load one accepted detection; on the final word, run suppression.
  task automatic predict_detection(pbs_det_t det);
    int       order[$];
    bit       dropped[];
    int       k;
    int       tmp;
    int       n;
    pbs_res_t res;
    if (det.score > score_thr && frame_dets.size() < MAX_DET) frame_dets = {frame_dets, det};
    if (!det.final_item) return;
    n = frame_dets.size();
    for (int i = 0; i < n; i++) order = {order, i};
    for (int i = 1; i < n; i++) begin
      k = i;
      while (k > 0 && ranks_ahead(frame_dets[order[k]], order[k],
                                  frame_dets[order[k-1]], order[k-1])) begin
        tmp = order[k]; order[k] = order[k-1]; order[k-1] = tmp;
        k--;
      end
    end
    dropped = new[n];
    k = 0;
    for (int i = 0; i < n; i++) begin
      if (!dropped[order[i]]) begin
        res = '0;
        res.kept_x      = frame_dets[order[i]].ctr_x;
        res.kept_y      = frame_dets[order[i]].ctr_y;
        res.kept_width  = frame_dets[order[i]].box_width;
        res.kept_height = frame_dets[order[i]].box_height;
        res.kept_score  = frame_dets[order[i]].score;
        res.kept_class  = frame_dets[order[i]].class_label;
        expected_results = {expected_results, res};
        k++;
        for (int j = i + 1; j < n; j++) begin
          if (frame_dets[order[j]].class_label != frame_dets[order[i]].class_label) break;
          if (!dropped[order[j]] && overlap_exceeds(frame_dets[order[i]], frame_dets[order[j]]))
            dropped[order[j]] = 1;
        end
      end
    end
    if (k == 0) begin
      res = '0;
      res.none_kept = 1;
      expected_results = {expected_results, res};
    end
    expected_results[expected_results.size()-1].run_end = 1;
    frame_dets.delete();
  endtask

  // Clock.
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Sender: offers queued words with random gaps, changing at falling edges.
  int send_gap;
  initial begin
    det_ch.valid = 0;
    det_ch.ctr_x = 0; det_ch.ctr_y = 0; det_ch.box_width = 0;
    det_ch.box_height = 0; det_ch.score = 0; det_ch.class_label = 0;
    det_ch.final_item = 0;
    send_gap = 0;
  end

  bit det_accepted;
  always @(posedge clk) begin
    det_accepted <= rst_n && det_ch.valid && det_ch.ready;
    if (rst_n && det_ch.valid && det_ch.ready) begin
      predict_detection(pbs_det_t'({det_ch.ctr_x, det_ch.ctr_y, det_ch.box_width,
                                    det_ch.box_height, det_ch.score, det_ch.class_label,
                                    det_ch.final_item}));
      sent_count <= sent_count + 1;
    end
  end

  always @(negedge clk) begin
    pbs_det_t d;
    if (rst_n) begin
      if (det_accepted || !det_ch.valid) begin
        if (send_gap > 0 || pending_dets.size() == 0) begin
          det_ch.valid <= 0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          d = pending_dets.pop_front();
          det_ch.valid       <= 1;
          det_ch.ctr_x       <= d.ctr_x;
          det_ch.ctr_y       <= d.ctr_y;
          det_ch.box_width   <= d.box_width;
          det_ch.box_height  <= d.box_height;
          det_ch.score       <= d.score;
          det_ch.class_label <= d.class_label;
          det_ch.final_item  <= d.final_item;
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off, and result checking.
  int recv_gap;
  initial begin
    res_ch.ready = 0;
    recv_gap = 0;
    hold_off_left = 0;
    mismatch_count = 0;
    sent_count = 0;
    frame_end_count = 0;
  end

  // Long hold-off counter.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off_req) begin
        hold_off_req  <= 0;
        hold_off_left <= 400;
      end else if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off_req || hold_off_left > 0) begin
        res_ch.ready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap     <= recv_gap - 1;
        res_ch.ready <= 0;
      end else begin
        res_ch.ready <= 1;
        if (res_ch.valid && res_ch.ready)
          recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      end
    end
  end

  always @(posedge clk) begin
    pbs_res_t got;
    pbs_res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = {res_ch.kept_x, res_ch.kept_y, res_ch.kept_width, res_ch.kept_height,
             res_ch.kept_score, res_ch.kept_class, res_ch.run_end, res_ch.none_kept};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %h, got %h", want, got);
        end
      end
      if (got.run_end) frame_end_count++;
    end
  end

  // Configuration write over the register port while the core is idle.
  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [15:0] value);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_SCORE_THR) score_thr = value;
    else ovl_thr = value;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Wait until all queued words are accepted and all results returned.
  task automatic drain();
    while (pending_dets.size() != 0 || det_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic pbs_det_t random_det(bit last_word);
    pbs_det_t d;
    d.ctr_x       = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(800, 1600));
    d.ctr_y       = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(800, 1600));
    d.box_width   = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 900));
    d.box_height  = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 900));
    d.score       = $urandom_range(0, 5) == 0 ? 16'($urandom_range(0, 3)) * 16'h5555
                                              : 16'($urandom);
    d.class_label = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
    d.final_item  = last_word;
    return d;
  endfunction

  function automatic pbs_det_t make_det(int cx, int cy, int w, int h, int sc, int cl, bit f);
    pbs_det_t d;
    d = {16'(cx), 16'(cy), 16'(w), 16'(h), 16'(sc), 8'(cl), f};
    return d;
  endfunction

  // Append one word to the sender's queue.
  task automatic enqueue_det(pbs_det_t d);
    pending_dets = {pending_dets, d};
  endtask

  task automatic queue_frame(int len);
    for (int i = 0; i < len; i++) enqueue_det(random_det(i == len - 1));
  endtask

  // Stimulus.
  initial begin
    int frame_len;
    int total;
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    hold_off_req = 0;
    score_thr = SCORE_THR_RST;
    ovl_thr = OVL_THR_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: default thresholds, overlaps, ties, zero area, dropped final.
    enqueue_det(make_det(1000, 1000, 400, 400, 60000, 1, 0));
    enqueue_det(make_det(1010, 1000, 400, 400, 50000, 1, 0));
    enqueue_det(make_det(1010, 1000, 400, 400, 50000, 1, 0));
    enqueue_det(make_det(1000, 1000, 400, 400, 55000, 0, 0));
    enqueue_det(make_det(1400, 1000, 400, 400, 40000, 0, 0));
    enqueue_det(make_det(1000, 1000, 0, 0, 40000, 0, 0));
    enqueue_det(make_det(65535, 65535, 65535, 65535, 65535, 255, 0));
    enqueue_det(make_det(0, 0, 65535, 65535, 65535, 255, 0));
    enqueue_det(make_det(1, 1, 1, 1, 16384, 2, 1));
    enqueue_det(make_det(5, 5, 5, 5, 100, 3, 1));
    enqueue_det(make_det(0, 0, 0, 0, 0, 0, 1));
    enqueue_det(make_det(100, 100, 10, 10, 16385, 7, 1));
    drain();

    // Extremes of both thresholds, then a mid setting.
    write_reg(ADDR_SCORE_THR, 16'd0);
    write_reg(ADDR_OVL_THR, 16'd0);
    enqueue_det(make_det(100, 100, 20, 20, 1, 4, 0));
    enqueue_det(make_det(110, 100, 20, 20, 2, 4, 0));
    enqueue_det(make_det(120, 100, 20, 20, 3, 4, 1));
    // Store overflow: 70 detections in one frame.
    for (int i = 0; i < 70; i++)
      enqueue_det(make_det(i * 37, 500, 30, 30, 1000 + i, i % 3, i == 69));
    drain();
    write_reg(ADDR_SCORE_THR, 16'd65535);
    write_reg(ADDR_OVL_THR, 16'd65535);
    queue_frame(4);
    drain();
    write_reg(ADDR_SCORE_THR, 16'd8000);
    write_reg(ADDR_OVL_THR, 16'd20000);

    // Long receiver hold-off while the sender keeps offering.
    hold_off_req = 1;
    queue_frame(30);
    queue_frame(6);
    drain();

    // Random frames, a few threshold changes along the way.
    total = 0;
    while (total < 195) begin
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 12);
      queue_frame(frame_len);
      total += frame_len;
      if ($urandom_range(0, 7) == 0) begin
        drain();
        write_reg(ADDR_SCORE_THR, 16'($urandom_range(0, 40000)));
        write_reg(ADDR_OVL_THR, 16'($urandom));
      end
    end
    drain();

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("per_class_box_suppression_core_tb: done, clean");
    else
      $display("per_class_box_suppression_core_tb: done, errors");
    $finish;
  end

  // Watchdog.
  initial begin
    #80ms;
    $display("per_class_box_suppression_core_tb: done, errors");
    $finish;
  end

endmodule
